// ===== design/smr_pkg.sv =====
// ----------------------------------------------------------------------------
// smr_pkg
// shared constants for the spiral order matrix reader: matrix limits, field
// widths and configuration register indexes
// ----------------------------------------------------------------------------
package smr_pkg;

  localparam int unsigned MAX_ROWS  = 8;
  localparam int unsigned MAX_COLS  = 8;
  localparam int unsigned ROW_W     = $clog2(MAX_ROWS);
  localparam int unsigned COL_W     = $clog2(MAX_COLS);
  localparam int unsigned DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W    = ROW_W + COL_W;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIM_W     = 4;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

endpackage

// ===== design/smr_ram.sv =====
// ----------------------------------------------------------------------------
// smr_ram
// simple dual-port ram: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module smr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/spiral_order_matrix_reader_core.sv =====
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader_core
// loading takes one element per cycle while the input is ready; the final
// element starts the spiral; results pass the ram read and output registers,
// one per cycle while the receiver is ready, set by the single ram read port
// input is held off until the last result of the spiral has transferred
// reset (async, active low) clears counters and sets both sizes to 8; the
// matrix ram is not cleared
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [smr_pkg::DATA_W-1:0]   element_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [smr_pkg::DATA_W-1:0]   out_value_o,
  output logic        [smr_pkg::ROW_W-1:0]    out_row_o,
  output logic        [smr_pkg::COL_W-1:0]    out_col_o,
  output logic                                is_last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [smr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [smr_pkg::DIM_W-1:0]    cfg_data_i
);

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_e;

  // configuration
  logic [smr_pkg::DIM_W-1:0] row_count_q, row_count_d;
  logic [smr_pkg::DIM_W-1:0] col_count_q, col_count_d;

  // load position
  logic [smr_pkg::ROW_W-1:0] ld_row_q, ld_row_d;
  logic [smr_pkg::COL_W-1:0] ld_col_q, ld_col_d;

  // spiral walker
  logic                      busy_q, busy_d;
  logic                      gen_active_q, gen_active_d;
  dir_e                      dir_q, dir_d;
  logic [smr_pkg::ROW_W-1:0] pos_row_q, pos_row_d;
  logic [smr_pkg::COL_W-1:0] pos_col_q, pos_col_d;
  logic [smr_pkg::ROW_W-1:0] top_q, top_d, bot_q, bot_d;
  logic [smr_pkg::COL_W-1:0] lft_q, lft_d, rgt_q, rgt_d;
  logic [smr_pkg::CNT_W-1:0] remain_q, remain_d;

  // read stage (ram output register) and output register
  logic                      s1_valid_q, s1_valid_d;
  logic [smr_pkg::ROW_W-1:0] s1_row_q, s1_row_d;
  logic [smr_pkg::COL_W-1:0] s1_col_q, s1_col_d;
  logic                      s1_last_q, s1_last_d;
  logic                      out_valid_q, out_valid_d;
  logic [smr_pkg::DATA_W-1:0] out_value_q, out_value_d;
  logic [smr_pkg::ROW_W-1:0] out_row_q, out_row_d;
  logic [smr_pkg::COL_W-1:0] out_col_q, out_col_d;
  logic                      out_last_q, out_last_d;

  logic [smr_pkg::DIM_W-1:0]  eff_rows, eff_cols;
  logic [smr_pkg::ROW_W-1:0]  rows_m1;
  logic [smr_pkg::COL_W-1:0]  cols_m1;
  logic [smr_pkg::CNT_W-1:0]  total;
  logic                       size_zero;
  logic                       in_xfer, cfg_xfer, out_xfer;
  logic                       ld_we, start;
  logic                       out_adv, s1_move, issue;
  logic [smr_pkg::DATA_W-1:0] ram_rdata;

  assign eff_rows  = (row_count_q > smr_pkg::DIM_W'(smr_pkg::MAX_ROWS)) ?
                     smr_pkg::DIM_W'(smr_pkg::MAX_ROWS) : row_count_q;
  assign eff_cols  = (col_count_q > smr_pkg::DIM_W'(smr_pkg::MAX_COLS)) ?
                     smr_pkg::DIM_W'(smr_pkg::MAX_COLS) : col_count_q;
  assign rows_m1   = smr_pkg::ROW_W'(eff_rows - smr_pkg::DIM_W'(1));
  assign cols_m1   = smr_pkg::COL_W'(eff_cols - smr_pkg::DIM_W'(1));
  assign total     = smr_pkg::CNT_W'(eff_rows) * smr_pkg::CNT_W'(eff_cols);
  assign size_zero = (eff_rows == '0) || (eff_cols == '0);

  assign in_ready_o  = !busy_q;
  assign cfg_ready_o = !busy_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;

  assign ld_we = in_xfer && !size_zero;
  assign start = ld_we && (ld_col_q == cols_m1) && (ld_row_q == rows_m1);

  assign out_adv = !out_valid_q || out_ready_i;
  assign s1_move = s1_valid_q && out_adv;
  assign issue   = gen_active_q && (!s1_valid_q || out_adv);

  smr_ram #(
    .WIDTH (smr_pkg::DATA_W),
    .DEPTH (smr_pkg::DEPTH)
  ) u_matrix_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i ({ld_row_q, ld_col_q}),
    .wdata_i (element_value_i),
    .re_i    (issue),
    .raddr_i ({pos_row_q, pos_col_q}),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    row_count_d  = row_count_q;
    col_count_d  = col_count_q;
    ld_row_d     = ld_row_q;
    ld_col_d     = ld_col_q;
    busy_d       = busy_q;
    gen_active_d = gen_active_q;
    dir_d        = dir_q;
    pos_row_d    = pos_row_q;
    pos_col_d    = pos_col_q;
    top_d        = top_q;
    bot_d        = bot_q;
    lft_d        = lft_q;
    rgt_d        = rgt_q;
    remain_d     = remain_q;
    s1_valid_d   = s1_valid_q;
    s1_row_d     = s1_row_q;
    s1_col_d     = s1_col_q;
    s1_last_d    = s1_last_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_last_d   = out_last_q;

    // register writes restart the load
    if (cfg_xfer) begin
      unique case (cfg_index_i)
        smr_pkg::REG_ROW_COUNT: begin
          row_count_d = cfg_data_i;
          ld_row_d    = '0;
          ld_col_d    = '0;
        end
        smr_pkg::REG_COL_COUNT: begin
          col_count_d = cfg_data_i;
          ld_row_d    = '0;
          ld_col_d    = '0;
        end
        default: begin
        end
      endcase
    end

    if (ld_we) begin
      if (ld_col_q == cols_m1) begin
        ld_col_d = '0;
        ld_row_d = (ld_row_q == rows_m1) ? '0 : ld_row_q + 1'b1;
      end else begin
        ld_col_d = ld_col_q + 1'b1;
      end
    end

    if (start) begin
      busy_d       = 1'b1;
      gen_active_d = 1'b1;
      dir_d        = DIR_RIGHT;
      pos_row_d    = '0;
      pos_col_d    = '0;
      top_d        = '0;
      bot_d        = rows_m1;
      lft_d        = '0;
      rgt_d        = cols_m1;
      remain_d     = total;
    end

    // each side ends by shrinking its bound and turning; the remaining count
    // ends the walk, so a side reached while elements remain is never empty
    if (issue) begin
      s1_row_d  = pos_row_q;
      s1_col_d  = pos_col_q;
      s1_last_d = (remain_q == smr_pkg::CNT_W'(1));
      remain_d  = remain_q - 1'b1;
      if (remain_q == smr_pkg::CNT_W'(1)) begin
        gen_active_d = 1'b0;
      end
      unique case (dir_q)
        DIR_RIGHT: begin
          if (pos_col_q == rgt_q) begin
            top_d     = top_q + 1'b1;
            dir_d     = DIR_DOWN;
            pos_row_d = top_q + 1'b1;
          end else begin
            pos_col_d = pos_col_q + 1'b1;
          end
        end
        DIR_DOWN: begin
          if (pos_row_q == bot_q) begin
            rgt_d     = rgt_q - 1'b1;
            dir_d     = DIR_LEFT;
            pos_col_d = rgt_q - 1'b1;
          end else begin
            pos_row_d = pos_row_q + 1'b1;
          end
        end
        DIR_LEFT: begin
          if (pos_col_q == lft_q) begin
            bot_d     = bot_q - 1'b1;
            dir_d     = DIR_UP;
            pos_row_d = bot_q - 1'b1;
          end else begin
            pos_col_d = pos_col_q - 1'b1;
          end
        end
        DIR_UP: begin
          if (pos_row_q == top_q) begin
            lft_d     = lft_q + 1'b1;
            dir_d     = DIR_RIGHT;
            pos_col_d = lft_q + 1'b1;
          end else begin
            pos_row_d = pos_row_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (issue) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end

    if (out_adv) begin
      out_valid_d = s1_valid_q;
      out_value_d = ram_rdata;
      out_row_d   = s1_row_q;
      out_col_d   = s1_col_q;
      out_last_d  = s1_last_q;
    end

    if (out_xfer && out_last_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q  <= smr_pkg::DIM_RESET;
      col_count_q  <= smr_pkg::DIM_RESET;
      ld_row_q     <= '0;
      ld_col_q     <= '0;
      busy_q       <= 1'b0;
      gen_active_q <= 1'b0;
      dir_q        <= DIR_RIGHT;
      remain_q     <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      row_count_q  <= row_count_d;
      col_count_q  <= col_count_d;
      ld_row_q     <= ld_row_d;
      ld_col_q     <= ld_col_d;
      busy_q       <= busy_d;
      gen_active_q <= gen_active_d;
      dir_q        <= dir_d;
      remain_q     <= remain_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_row_q   <= pos_row_d;
    pos_col_q   <= pos_col_d;
    top_q       <= top_d;
    bot_q       <= bot_d;
    lft_q       <= lft_d;
    rgt_q       <= rgt_d;
    s1_row_q    <= s1_row_d;
    s1_col_q    <= s1_col_d;
    s1_last_q   <= s1_last_d;
    out_value_q <= out_value_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign is_last_o   = out_last_q;

endmodule

// ===== design/smr_checker.sv =====
// ----------------------------------------------------------------------------
// smr_checker
// port-level checks on the spiral order matrix reader, bound to the top level
// ----------------------------------------------------------------------------
module smr_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [smr_pkg::DATA_W-1:0]   out_value_o,
  input logic        [smr_pkg::ROW_W-1:0]    out_row_o,
  input logic        [smr_pkg::COL_W-1:0]    out_col_o,
  input logic                                is_last_o,
  input logic                                cfg_ready_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_value_o)
      && $stable(out_row_o) && $stable(out_col_o) && $stable(is_last_o))
    else $error("stalled result changed");

  // no element is taken while a spiral is being delivered
  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o && !cfg_ready_o)
    else $error("input open while results pending");

  // the spiral continues after a transfer that is not the last
  a_busy_mid_spiral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !is_last_o |=> !in_ready_o)
    else $error("block went idle in the middle of a spiral");

  // the last transfer frees the input
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && is_last_o |=> in_ready_o && !out_valid_o)
    else $error("block not idle after last result");

endmodule

bind spiral_order_matrix_reader_core smr_checker u_smr_checker (.*);

// ===== sim/spiral_order_matrix_reader_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader_core_test
// loads matrices of many shapes, oversized and zero sizes included, and checks
// every spiral result field by field against an in-bench predictor; both
// channels idle and stall at random, and one long receiver hold-off fills the
// block so that it stalls its input
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader_core_test;
  import smr_pkg::*;

  localparam int unsigned ITEM_TARGET     = 150;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned N_SCRIPT        = 36;

  // indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
  } spiral_beat_t;

  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_ELEM
  } step_kind_e;

  typedef struct packed {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     data;
    logic [DATA_W-1:0]    value;
    logic                 typed;
    spiral_beat_t         beat;
  } directed_row_t;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_ready_o;
  logic signed [DATA_W-1:0]   element_value_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i     = 1'b0;
  logic signed [DATA_W-1:0]   out_value_o;
  logic        [ROW_W-1:0]    out_row_o;
  logic        [COL_W-1:0]    out_col_o;
  logic                       is_last_o;
  logic                       cfg_valid_i     = 1'b0;
  logic                       cfg_ready_o;
  logic        [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic        [DIM_W-1:0]    cfg_data_i      = '0;

  spiral_order_matrix_reader_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_value_o     (out_value_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .is_last_o       (is_last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [DATA_W-1:0] matrix_shadow [DEPTH];
  int unsigned       load_shadow = 0;
  logic [DIM_W-1:0]  row_setting = DIM_RESET;
  logic [DIM_W-1:0]  col_setting = DIM_RESET;
  spiral_beat_t      fresh_beats [$];
  spiral_beat_t      spiral_expect_q [$];

  int unsigned items_loaded  = 0;
  int unsigned items_dropped = 0;
  int unsigned results_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  bit          calm_mode     = 1'b0;
  bit          hold_req      = 1'b0;

  directed_row_t script [N_SCRIPT];

  function automatic int unsigned effective_dim(logic [DIM_W-1:0] d, int unsigned lim);
    return (d > lim) ? lim : int'(d);
  endfunction

  function automatic void append_spiral_beat(int r, int c);
    spiral_beat_t b;
    b.value = matrix_shadow[r * MAX_COLS + c];
    b.row   = ROW_W'(r);
    b.col   = COL_W'(c);
    b.last  = 1'b0;
    fresh_beats.push_back(b);
  endfunction

  // returns 1 when the element was taken into the load
  function automatic bit absorb_element(logic [DATA_W-1:0] v);
    int unsigned  rows, cols, total;
    int           top, bot, lft, rgt, i;
    spiral_beat_t tail;
    fresh_beats.delete();
    rows  = effective_dim(row_setting, MAX_ROWS);
    cols  = effective_dim(col_setting, MAX_COLS);
    total = rows * cols;
    if (total == 0) return 1'b0;
    if (load_shadow >= total) load_shadow = 0;
    matrix_shadow[(load_shadow / cols) * MAX_COLS + (load_shadow % cols)] = v;
    load_shadow++;
    if (load_shadow < total) return 1'b1;
    load_shadow = 0;
    top = 0;
    bot = int'(rows) - 1;
    lft = 0;
    rgt = int'(cols) - 1;
    while (top <= bot && lft <= rgt) begin
      for (i = lft; i <= rgt; i++) append_spiral_beat(top, i);
      top++;
      for (i = top; i <= bot; i++) append_spiral_beat(i, rgt);
      rgt--;
      // bottom row and left column only when not already covered
      if (top <= bot) begin
        for (i = rgt; i >= lft; i--) append_spiral_beat(bot, i);
        bot--;
      end
      if (lft <= rgt) begin
        for (i = bot; i >= top; i--) append_spiral_beat(i, lft);
        lft++;
      end
    end
    tail = fresh_beats[fresh_beats.size() - 1];
    tail.last = 1'b1;
    fresh_beats[fresh_beats.size() - 1] = tail;
    return 1'b1;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    case (idx)
      REG_ROW_COUNT: begin
        row_setting = data;
        load_shadow = 0;
      end
      REG_COL_COUNT: begin
        col_setting = data;
        load_shadow = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 8) return DIM_W'($urandom_range(1, 4));
    return DIM_W'($urandom_range(5, 15));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_IDX_W-1:0] pick_spare();
    return ($urandom_range(0, 1) != 0) ? SPARE_REG_A : SPARE_REG_B;
  endfunction

  function automatic directed_row_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    directed_row_t s;
    s       = '0;
    s.kind  = STEP_CFG;
    s.idx   = idx;
    s.data  = data;
    return s;
  endfunction

  function automatic directed_row_t elem_step(logic [DATA_W-1:0] v);
    directed_row_t s;
    s       = '0;
    s.kind  = STEP_ELEM;
    s.value = v;
    return s;
  endfunction

  function automatic directed_row_t checked_step(logic [DATA_W-1:0] v, spiral_beat_t b);
    directed_row_t s;
    s       = elem_step(v);
    s.typed = 1'b1;
    s.beat  = b;
    return s;
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch on result %0d: %s", results_seen, what);
  endfunction

  task automatic send_element(logic [DATA_W-1:0] v, bit typed, spiral_beat_t typed_beat);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    if (absorb_element(v)) items_loaded++;
    else items_dropped++;
    if (typed) spiral_expect_q.push_back(typed_beat);
    else foreach (fresh_beats[k]) spiral_expect_q.push_back(fresh_beats[k]);
  endtask

  // registers change only with the block idle
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (spiral_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_element(pick_value(), 1'b0, '0);
  endtask

  // result side: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int unsigned stall_left;
    bit          held;
    stall_left = 0;
    held       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    spiral_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (spiral_expect_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer value %0d row %0d col %0d last %0b",
                                out_value_o, out_row_o, out_col_o, is_last_o));
      end else begin
        want = spiral_expect_q.pop_front();
        if (out_value_o !== want.value)
          flag_mismatch($sformatf("value expected %0d got %0d",
                                  $signed(want.value), out_value_o));
        if (out_row_o !== want.row)
          flag_mismatch($sformatf("row expected %0d got %0d", want.row, out_row_o));
        if (out_col_o !== want.col)
          flag_mismatch($sformatf("col expected %0d got %0d", want.col, out_col_o));
        if (is_last_o !== want.last)
          flag_mismatch($sformatf("last expected %0b got %0b", want.last, is_last_o));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("spiral_order_matrix_reader_core_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [DIM_W-1:0] rows, cols;
    int unsigned      total, n_mat, split, phase;

    script = '{
      cfg_step(REG_ROW_COUNT, 4'd1),
      cfg_step(REG_COL_COUNT, 4'd1),
      checked_step(32'h7fff_ffff, '{32'h7fff_ffff, 3'd0, 3'd0, 1'b1}),
      checked_step(32'h8000_0000, '{32'h8000_0000, 3'd0, 3'd0, 1'b1}),
      checked_step(32'hffff_ffff, '{32'hffff_ffff, 3'd0, 3'd0, 1'b1}),
      // zero rows: element dropped
      cfg_step(REG_ROW_COUNT, 4'd0),
      elem_step(32'h5555_5555),
      // oversized column count acts as eight
      cfg_step(REG_ROW_COUNT, 4'd1),
      cfg_step(REG_COL_COUNT, 4'd12),
      elem_step(32'h0000_0000),
      elem_step(32'h0000_0001),
      elem_step(32'h7fff_fffe),
      elem_step(32'h8000_0001),
      elem_step(32'haaaa_aaaa),
      elem_step(32'h5555_5555),
      elem_step(32'hdead_beef),
      elem_step(32'h0bad_f00d),
      // unused indexes in mid-load leave the load running
      cfg_step(REG_ROW_COUNT, 4'd3),
      cfg_step(REG_COL_COUNT, 4'd2),
      elem_step(32'h0000_0011),
      elem_step(32'h0000_0012),
      cfg_step(SPARE_REG_A, 4'd15),
      cfg_step(SPARE_REG_B, 4'd0),
      elem_step(32'h0000_0021),
      elem_step(32'h0000_0022),
      elem_step(32'h0000_0031),
      elem_step(32'h0000_0032),
      // a real write restarts the load
      cfg_step(REG_COL_COUNT, 4'd3),
      elem_step(32'hffff_0000),
      cfg_step(REG_ROW_COUNT, 4'd2),
      elem_step(32'h1000_0000),
      elem_step(32'h2000_0000),
      elem_step(32'h3000_0000),
      elem_step(32'h4000_0000),
      elem_step(32'h5000_0000),
      elem_step(32'h6000_0000)
    };

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[n]) begin
      if (script[n].kind == STEP_CFG) write_register(script[n].idx, script[n].data);
      else send_element(script[n].value, script[n].typed, script[n].beat);
    end

    phase = 0;
    while (items_loaded < ITEM_TARGET) begin
      calm_mode = (phase % 4 == 3);
      if (phase == 0) begin
        rows = 4'd8;
        cols = 4'd15;
      end else if (phase == 1) begin
        rows = 4'd2;
        cols = 4'd2;
      end else begin
        rows = pick_dim();
        cols = pick_dim();
      end
      if ($urandom_range(0, 5) == 0) write_register(pick_spare(), DIM_W'($urandom_range(0, 15)));
      write_register(REG_ROW_COUNT, rows);
      write_register(REG_COL_COUNT, cols);
      total = effective_dim(rows, MAX_ROWS) * effective_dim(cols, MAX_COLS);
      // receiver holds off while the sender keeps offering small matrices
      if (phase == 1) hold_req = 1'b1;
      if (total == 0) begin
        send_random($urandom_range(1, 3));
      end else begin
        n_mat = (phase == 1) ? 6 : ((total > 16) ? 1 : $urandom_range(1, 3));
        repeat (n_mat) begin
          if (total > 1 && $urandom_range(0, 3) == 0) begin
            split = $urandom_range(1, total - 1);
            send_random(split);
            write_register(pick_spare(), DIM_W'($urandom_range(0, 15)));
            send_random(total - split);
          end else begin
            send_random(total);
          end
        end
        // abandoned load, discarded by the next row or column count write
        if (total > 1 && $urandom_range(0, 3) == 0) send_random($urandom_range(1, total - 1));
      end
      phase++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (spiral_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d elements loaded, %0d dropped on zero size, %0d register writes, %0d phases",
             items_loaded, items_dropped, cfg_writes, phase);
    $display("%0d spiral results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && spiral_expect_q.size() == 0) begin
      $display("spiral_order_matrix_reader_core_test passed");
    end else begin
      $display("spiral_order_matrix_reader_core_test failed");
    end
    $finish;
  end

endmodule
